/* hdl/vcr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vcr_pkg: shared types and constants of the varispeed cubic resampler
// Word formats, operation and register codes, sequencer states and the
// control word that the sequencer hands to the interpolation unit.
// ----------------------------------------------------------------------------
package vcr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FRAME_W     = 2 * SAMPLE_W;
  localparam int ADDR_W      = 14;
  localparam int TLEN_W      = 15;
  localparam int SPEED_W     = 19;
  localparam int CFG_DATA_W  = 19;
  localparam int CFG_INDEX_W = 2;
  localparam int OP_W        = 2;

  // Interpolator arithmetic: fraction, coefficient and accumulator widths.
  localparam int T_W      = 16;
  localparam int K_W      = 20;
  localparam int ACC_FRAC = 16;
  localparam int ACC_W    = 38;
  localparam int HI_W     = ACC_W - ACC_FRAC;
  localparam int MUL_B_W  = T_W + 1;
  localparam int PROD_W   = HI_W + MUL_B_W;

  localparam int WINDOW_TAPS = 4;
  localparam int LEN_MIN     = 4;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_SEEK    = 2'd1;
  localparam logic [OP_W-1:0] OP_PRODUCE = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_TRACK_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_RATE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLAY_MODE    = 2'd2;

  // Speed 4.0 is the ceiling; below 656 (0.01 in 3.16) the output is silent.
  localparam logic [SPEED_W-1:0] SPEED_MAX = 19'd262144;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 19'd656;

  localparam logic MODE_PASSTHROUGH = 1'b0;
  localparam logic MODE_TURNTABLE   = 1'b1;

  typedef logic [WINDOW_TAPS-1:0][FRAME_W-1:0] window_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_ADDR,
    ST_FETCH,
    ST_PASS_RD,
    ST_PASS_CAP,
    ST_COEF,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ROUND,
    ST_ADVANCE,
    ST_FINAL
  } seq_state_t;

  typedef enum logic [1:0] {
    STEP_K2,
    STEP_K1,
    STEP_K0
  } step_t;

  typedef struct packed {
    logic  coef;
    logic  mul_hi;
    logic  mul_lo;
    step_t step;
    logic  channel;
  } interp_ctl_t;

endpackage
`default_nettype wire

/* hdl/varispeed_cubic_resampler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// varispeed_cubic_resampler: varispeed stereo playback with cubic interpolation
// Source frames live in a single-port store; a sequencer walks one shared
// multiplier through a four-point Catmull-Rom evaluation for each channel.
// ----------------------------------------------------------------------------
// Load and seek words are taken while idle and busy stays low.
// A produce word keeps busy high while its result is formed, when silent,
// in passthrough and in turntable mode; the strobe follows the last busy cycle.
// Turntable work is bounded by the single store port (four reads) and the
// one shared multiplier, which takes each Horner step per channel in two halves.
// Synchronous active-low reset restores the registers to their defaults and
// the play position to zero; the source store is not cleared.
module varispeed_cubic_resampler #(
  parameter int SOURCE_FRAMES = 16384,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Command channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic        [vcr_pkg::OP_W-1:0]      in_op,
  input  wire logic        [vcr_pkg::ADDR_W-1:0]    in_address,
  input  wire logic signed [vcr_pkg::SAMPLE_W-1:0]  in_left_in,
  input  wire logic signed [vcr_pkg::SAMPLE_W-1:0]  in_right_in,
  // Result channel
  output logic                                      out_valid,
  output logic signed      [vcr_pkg::SAMPLE_W-1:0]  out_left_out,
  output logic signed      [vcr_pkg::SAMPLE_W-1:0]  out_right_out,
  output logic             [vcr_pkg::ADDR_W-1:0]    out_position_out,
  output logic                                      out_saturated,
  // Configuration channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic        [vcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [vcr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import vcr_pkg::*;

  // Store address width, width of frame counts and of the play position.
  // The count width leaves room for a position that has just run past the end.
  localparam int AW = $clog2(SOURCE_FRAMES);
  localparam int LW = (AW + 1 > TLEN_W) ? AW + 1 : TLEN_W;
  localparam int PW = LW + FRACTION_BITS;
  localparam logic [LW-1:0] LEN_MAX = LW'(SOURCE_FRAMES);
  localparam logic [2:0]    FETCH_DONE = 3'(WINDOW_TAPS);

  // Configuration registers
  logic [TLEN_W-1:0]  track_len_r;
  logic [SPEED_W-1:0] speed_r;
  logic               mode_r;

  // Sequencer and datapath registers
  seq_state_t            state_r, state_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         rd_addr_r, rd_addr_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  step_t                 step_r, step_nxt;
  logic                  ch_r, ch_nxt;
  logic [T_W-1:0]        t_r, t_nxt;
  window_t               window_r, window_nxt;
  logic [SAMPLE_W-1:0]   left_r, left_nxt, right_r, right_nxt;
  logic                  clip_r, clip_nxt;
  logic [ADDR_W-1:0]     pos_out_r, pos_out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  accept, load_we;
  logic [LW-1:0]         tl_ext, len, len_m1, len_m3, addr_ext, seek_int;
  logic [LW-1:0]         pos_int, win_idx;
  logic [SPEED_W-1:0]    spd;
  logic                  speed_ok;
  logic [SPEED_W+FRACTION_BITS-1:0] spd_wide;
  logic [PW-1:0]         spd_step, pos_clamped;
  logic [FRACTION_BITS+T_W-1:0]     t_wide;
  logic [AW-1:0]         ram_addr;
  logic [FRAME_W-1:0]    ram_rdata;
  interp_ctl_t           ctl;
  logic [SAMPLE_W-1:0]   interp_sample;
  logic                  interp_clip;

  // A position whose frame is at or past the length lands on the last frame.
  function automatic logic [PW-1:0] clamp_pos(input logic [PW-1:0] p,
                                              input logic [LW-1:0] n);
    if (p[PW-1:FRACTION_BITS] >= n) begin
      return {n - LW'(1), {FRACTION_BITS{1'b0}}};
    end
    return p;
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Effective length is the register held to 4..SOURCE_FRAMES.
  always_comb begin
    tl_ext = LW'(track_len_r);
    if (tl_ext < LW'(LEN_MIN)) begin
      len = LW'(LEN_MIN);
    end else if (tl_ext > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = tl_ext;
    end
  end

  assign len_m1 = len - LW'(1);
  assign len_m3 = len - LW'(3);

  // Speed is held at 4.0 and rescaled from 16 fraction bits to the position's.
  assign spd      = (speed_r > SPEED_MAX) ? SPEED_MAX : speed_r;
  assign speed_ok = (spd >= SPEED_MIN);
  assign spd_wide = {spd, {FRACTION_BITS{1'b0}}} >> 16;
  assign spd_step = PW'(spd_wide[FRACTION_BITS+2:0]);

  assign pos_int     = pos_r[PW-1:FRACTION_BITS];
  assign pos_clamped = clamp_pos(pos_r, len);
  assign t_wide      = {pos_r[FRACTION_BITS-1:0], {T_W{1'b0}}} >> FRACTION_BITS;

  // The window starts one frame before the index, which is kept in 1..len-3.
  assign win_idx = (pos_int < LW'(1)) ? LW'(1) :
                   (pos_int > len_m3) ? len_m3 : pos_int;

  assign addr_ext = LW'(in_address);
  assign seek_int = (addr_ext >= len) ? len_m1 : addr_ext;
  assign load_we  = accept && (in_op == OP_LOAD) && (addr_ext < LEN_MAX);
  assign ram_addr = load_we ? addr_ext[AW-1:0] : rd_addr_r;

  vcr_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (SOURCE_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .addr  (ram_addr),
    .wdata ({in_left_in, in_right_in}),
    .rdata (ram_rdata)
  );

  vcr_interp u_interp (
    .clk    (clk),
    .ctl    (ctl),
    .window (window_r),
    .t_frac (t_r),
    .sample (interp_sample),
    .clip   (interp_clip)
  );

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_len_r <= TLEN_W'(16384);
      speed_r     <= SPEED_W'(65536);
      mode_r      <= MODE_PASSTHROUGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TRACK_LENGTH: track_len_r <= cfg_data[TLEN_W-1:0];
        CFG_SPEED_RATE:   speed_r     <= cfg_data[SPEED_W-1:0];
        CFG_PLAY_MODE:    mode_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    rd_addr_nxt   = rd_addr_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    ch_nxt        = ch_r;
    t_nxt         = t_r;
    window_nxt    = window_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    clip_nxt      = clip_r;
    pos_out_nxt   = pos_out_r;
    out_valid_nxt = 1'b0;
    ctl.coef      = 1'b0;
    ctl.mul_hi    = 1'b0;
    ctl.mul_lo    = 1'b0;
    ctl.step      = step_r;
    ctl.channel   = ch_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_SEEK) begin
            pos_nxt = {seek_int, {FRACTION_BITS{1'b0}}};
          end else if (in_op == OP_PRODUCE) begin
            left_nxt  = '0;
            right_nxt = '0;
            clip_nxt  = 1'b0;
            state_nxt = ST_CLAMP;
          end
        end
      end
      ST_CLAMP: begin
        pos_nxt   = pos_clamped;
        state_nxt = speed_ok ? ST_ADDR : ST_FINAL;
      end
      ST_ADDR: begin
        t_nxt = t_wide[T_W-1:0];
        if (mode_r == MODE_TURNTABLE) begin
          rd_addr_nxt = AW'(win_idx - LW'(1));
          cnt_nxt     = '0;
          ch_nxt      = 1'b0;
          state_nxt   = ST_FETCH;
        end else begin
          rd_addr_nxt = pos_int[AW-1:0];
          state_nxt   = ST_PASS_RD;
        end
      end
      ST_FETCH: begin
        // Read data arrives in the cycle after its address, so the first pass only
        // issues an address and the last pass only takes in the last frame.
        if (cnt_r != '0) begin
          window_nxt = {ram_rdata, window_r[WINDOW_TAPS-1:1]};
        end
        if (cnt_r == FETCH_DONE) begin
          state_nxt = ST_COEF;
        end else begin
          rd_addr_nxt = rd_addr_r + AW'(1);
          cnt_nxt     = cnt_r + 3'd1;
        end
      end
      ST_PASS_RD: begin
        state_nxt = ST_PASS_CAP;
      end
      ST_PASS_CAP: begin
        left_nxt  = ram_rdata[FRAME_W-1:SAMPLE_W];
        right_nxt = ram_rdata[SAMPLE_W-1:0];
        pos_nxt   = pos_r + (PW'(1) << FRACTION_BITS);
        state_nxt = ST_FINAL;
      end
      ST_COEF: begin
        ctl.coef  = 1'b1;
        step_nxt  = STEP_K2;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        ctl.mul_hi = 1'b1;
        state_nxt  = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        ctl.mul_lo = 1'b1;
        unique case (step_r)
          STEP_K2: begin
            step_nxt  = STEP_K1;
            state_nxt = ST_MUL_HI;
          end
          STEP_K1: begin
            step_nxt  = STEP_K0;
            state_nxt = ST_MUL_HI;
          end
          default: begin
            state_nxt = ST_ROUND;
          end
        endcase
      end
      ST_ROUND: begin
        clip_nxt = clip_r | interp_clip;
        if (!ch_r) begin
          left_nxt  = interp_sample;
          ch_nxt    = 1'b1;
          state_nxt = ST_COEF;
        end else begin
          right_nxt = interp_sample;
          state_nxt = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        pos_nxt   = pos_r + spd_step;
        state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        pos_nxt       = pos_clamped;
        pos_out_nxt   = pos_clamped[FRACTION_BITS+ADDR_W-1:FRACTION_BITS];
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    cnt_r     <= cnt_nxt;
    step_r    <= step_nxt;
    ch_r      <= ch_nxt;
    t_r       <= t_nxt;
    window_r  <= window_nxt;
    left_r    <= left_nxt;
    right_r   <= right_nxt;
    clip_r    <= clip_nxt;
    pos_out_r <= pos_out_nxt;
  end

  // The result word stays in its registers; the strobe marks the one cycle.
  assign out_valid        = out_valid_r;
  assign out_left_out     = left_r;
  assign out_right_out    = right_r;
  assign out_position_out = pos_out_r;
  assign out_saturated    = clip_r;

endmodule
`default_nettype wire

/* hdl/vcr_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vcr_ram: generic single-port RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
module vcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hdl/vcr_interp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vcr_interp: Catmull-Rom coefficient, Horner and rounding unit
// One shared multiplier evaluates each Horner step as two partial products
// (integer half and fraction half of the accumulator), one after the other.
// ----------------------------------------------------------------------------
module vcr_interp (
  input  wire logic                                 clk,
  input  wire vcr_pkg::interp_ctl_t                 ctl,
  input  wire vcr_pkg::window_t                     window,
  input  wire logic        [vcr_pkg::T_W-1:0]       t_frac,
  output logic signed      [vcr_pkg::SAMPLE_W-1:0]  sample,
  output logic                                      clip
);
  import vcr_pkg::*;

  localparam int R_W = ACC_W - ACC_FRAC - 1;
  localparam logic signed [R_W-1:0]   SAT_HI = R_W'(32767);
  localparam logic signed [R_W-1:0]   SAT_LO = -R_W'(32768);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << ACC_FRAC;

  function automatic logic signed [K_W-1:0] sext(input logic [SAMPLE_W-1:0] s);
    return {{(K_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
  endfunction

  function automatic logic signed [ACC_W-1:0] kshift(input logic signed [K_W-1:0] k);
    return {{(ACC_W-ACC_FRAC-K_W){k[K_W-1]}}, k, {ACC_FRAC{1'b0}}};
  endfunction

  logic signed [K_W-1:0] y [WINDOW_TAPS];
  logic signed [K_W-1:0] k0, k1, k2, k3, d12, ksel;
  logic signed [K_W-1:0] k0_r, k1_r, k2_r, k0_nxt, k1_nxt, k2_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, rsum;
  logic signed [PROD_W-1:0] prod_r, prod_nxt, product;
  logic signed [HI_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [R_W-1:0] r;

  always_comb begin
    for (int i = 0; i < WINDOW_TAPS; i++) begin
      y[i] = ctl.channel ? sext(window[i][SAMPLE_W-1:0])
                         : sext(window[i][FRAME_W-1:SAMPLE_W]);
    end
  end

  // Coefficients are kept doubled so that they stay integer.
  assign d12 = y[1] - y[2];
  assign k0  = y[1] <<< 1;
  assign k1  = y[2] - y[0];
  assign k2  = (y[0] <<< 1) - (y[1] <<< 2) - y[1] + (y[2] <<< 2) - y[3];
  assign k3  = (y[3] - y[0]) + (d12 <<< 1) + d12;

  always_comb begin
    case (ctl.step)
      STEP_K2: ksel = k2_r;
      STEP_K1: ksel = k1_r;
      default: ksel = k0_r;
    endcase
  end

  // The shared multiplier: integer half of the accumulator while mul_hi is set,
  // the non-negative fraction half while mul_lo is set.
  assign mul_b   = {1'b0, t_frac};
  assign mul_a   = ctl.mul_lo ? {{(HI_W-ACC_FRAC){1'b0}}, acc_r[ACC_FRAC-1:0]}
                              : acc_r[ACC_W-1:ACC_FRAC];
  assign product = mul_a * mul_b;

  always_comb begin
    k0_nxt   = k0_r;
    k1_nxt   = k1_r;
    k2_nxt   = k2_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    if (ctl.coef) begin
      k0_nxt  = k0;
      k1_nxt  = k1;
      k2_nxt  = k2;
      acc_nxt = kshift(k3);
    end
    if (ctl.mul_hi) begin
      prod_nxt = product;
    end
    if (ctl.mul_lo) begin
      acc_nxt = prod_r[ACC_W-1:0] + ACC_W'(product[PROD_W-1:ACC_FRAC]) + kshift(ksel);
    end
  end

  always_ff @(posedge clk) begin
    k0_r   <= k0_nxt;
    k1_r   <= k1_nxt;
    k2_r   <= k2_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  // Round half up to Q1.15 and saturate.
  assign rsum = acc_r + ROUND_HALF;
  assign r    = $signed(rsum[ACC_W-1:ACC_FRAC+1]);

  always_comb begin
    clip = 1'b0;
    if (r > SAT_HI) begin
      sample = SAT_HI[SAMPLE_W-1:0];
      clip   = 1'b1;
    end else if (r < SAT_LO) begin
      sample = SAT_LO[SAMPLE_W-1:0];
      clip   = 1'b1;
    end else begin
      sample = r[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire
